### hw/rtl/pfc_pkg.sv
// Shared types, codes and helper functions for the Playfair stream cipher.
package pfc_pkg;

    localparam int SqCells = 25;
    localparam int Letters = 26;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_KEY    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_TEXT   = 2'd3;

    localparam logic [4:0] CODE_I      = 5'd8;
    localparam logic [4:0] CODE_J      = 5'd9;
    localparam logic [4:0] CODE_X      = 5'd23;
    localparam logic [4:0] CODE_LAST   = 5'd25;
    localparam logic [4:0] CODE_NONE   = 5'd26;
    localparam logic [4:0] CELLS_FULL  = 5'd25;

    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5A;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7A;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_char;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out;

    typedef struct packed {
        logic       clear;
        logic       place;
        logic [4:0] place_code;
        logic       pos_rd;
        logic [4:0] pos_a;
        logic [4:0] pos_b;
        logic       sq_rd;
        logic [4:0] sq_a0;
        logic [4:0] sq_a1;
    } t_key_cmd;

    typedef struct packed {
        logic [4:0] pa;
        logic [4:0] pb;
        logic [4:0] q0;
        logic [4:0] q1;
    } t_key_rsp;

    function automatic logic [4:0] letter_code(input logic [7:0] b);
        logic [4:0] c;
        c = CODE_NONE;
        if (b >= CHAR_UA && b <= CHAR_UZ) begin
            c = 5'(b - CHAR_UA);
        end else if (b >= CHAR_LA && b <= CHAR_LZ) begin
            c = 5'(b - CHAR_LA);
        end
        return c;
    endfunction

    function automatic logic [2:0] div5(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [4:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] step5(input logic [2:0] v, input logic dir);
        logic [3:0] s;
        s = {1'b0, v} + (dir ? 4'd4 : 4'd1);
        if (s >= 4'd5) begin
            s = s - 4'd5;
        end
        return s[2:0];
    endfunction

endpackage

### hw/rtl/pfc_keymem.sv
// Key square and letter position memories with fill and usage tracking.
module pfc_keymem
    import pfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_key_cmd i_cmd,
    output t_key_rsp o_rsp
);

    logic [4:0]  r_square [SqCells];
    logic [4:0]  r_pos    [Letters];
    logic [25:0] r_used;
    logic [4:0]  r_fill;
    logic [4:0]  r_pa_raw;
    logic [4:0]  r_pb_raw;
    logic        r_ua;
    logic        r_ub;
    logic [4:0]  r_q0;
    logic [4:0]  r_q1;
    logic        used_hit;
    logic        place_ok;

    assign used_hit = (i_cmd.place_code < CODE_NONE) ? r_used[i_cmd.place_code] : 1'b1;
    assign place_ok = i_cmd.place && (i_cmd.place_code != CODE_J)
                    && (r_fill < CELLS_FULL) && !used_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (place_ok) begin
            r_used[i_cmd.place_code] <= 1'b1;
            r_fill <= r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_square[r_fill]       <= i_cmd.place_code;
            r_pos[i_cmd.place_code] <= r_fill;
        end
        if (i_cmd.pos_rd) begin
            r_pa_raw <= r_pos[i_cmd.pos_a];
            r_pb_raw <= r_pos[i_cmd.pos_b];
            r_ua     <= r_used[i_cmd.pos_a];
            r_ub     <= r_used[i_cmd.pos_b];
        end
        if (i_cmd.sq_rd) begin
            r_q0 <= r_square[i_cmd.sq_a0];
            r_q1 <= r_square[i_cmd.sq_a1];
        end
    end

    // unplaced letters sit at cell zero
    assign o_rsp.pa = r_ua ? r_pa_raw : 5'd0;
    assign o_rsp.pb = r_ub ? r_pb_raw : 5'd0;
    assign o_rsp.q0 = r_q0;
    assign o_rsp.q1 = r_q1;

endmodule

### hw/rtl/playfair_stream_cipher_top.sv
// Top level of the Playfair stream cipher: sequencer, pair logic and output register.
//
//   channel   direction  signals                               payload
//   input     in         i_in_valid / o_in_ready               i_in_data (t_in)
//   output    out        o_out_valid / i_out_ready             o_out_data (t_out)
//   config    in         i_cfg_we                              i_cfg_wdata (direction)
//
// Clear, keyword and pair-opening text items finish in the idle state; a non-letter also passes the second load state.
// A closing letter goes through a position memory read, a key square read and two loads.
// Finish key square sends one letter per cycle through the memory write port.
// Reset is synchronous; the key square contents are not cleared.
// A stalled output holds the sequencer in its load states; input waits meanwhile.
module playfair_stream_cipher_top
    import pfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FIN  = 3'd1;
    localparam logic [2:0] ST_POS  = 3'd2;
    localparam logic [2:0] ST_EMA  = 3'd3;
    localparam logic [2:0] ST_EMB  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_dir;
    logic       r_pend_valid, n_pend_valid;
    logic [4:0] r_pend, n_pend;
    logic [4:0] r_fin_k, n_fin_k;
    logic       r_pass, n_pass;
    logic [7:0] r_byte, n_byte;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    t_key_cmd   key_cmd;
    t_key_rsp   key_rsp;

    logic       in_xfer;
    logic       out_free;
    logic [4:0] code;
    logic [4:0] tcode;
    logic [2:0] ar, ac, br, bc;

    pfc_keymem u_keymem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (key_cmd),
        .o_rsp   (key_rsp)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign code  = letter_code(i_in_data.in_char);
    assign tcode = (code == CODE_J) ? CODE_I : code;

    assign ar = div5(key_rsp.pa);
    assign br = div5(key_rsp.pb);
    assign ac = 3'(key_rsp.pa - cell_idx(ar, 3'd0));
    assign bc = 3'(key_rsp.pb - cell_idx(br, 3'd0));

    always_comb begin
        n_state      = r_state;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_fin_k      = r_fin_k;
        n_pass       = r_pass;
        n_byte       = r_byte;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        key_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.op)
                        OP_CLEAR: begin
                            key_cmd.clear = 1'b1;
                            n_pend_valid  = 1'b0;
                            n_pend        = '0;
                        end
                        OP_KEY: begin
                            key_cmd.place      = 1'b1;
                            key_cmd.place_code = code;
                        end
                        OP_FINISH: begin
                            n_fin_k = '0;
                            n_state = ST_FIN;
                        end
                        default: begin
                            if (code == CODE_NONE) begin
                                n_pass  = 1'b1;
                                n_byte  = i_in_data.in_char;
                                n_state = ST_EMB;
                            end else if (!r_pend_valid) begin
                                n_pend       = tcode;
                                n_pend_valid = 1'b1;
                            end else begin
                                key_cmd.pos_rd = 1'b1;
                                key_cmd.pos_a  = r_pend;
                                n_pass         = 1'b0;
                                n_state        = ST_POS;
                                if (tcode == r_pend) begin
                                    // doubled letter: pair with X, keep it open
                                    key_cmd.pos_b = CODE_X;
                                end else begin
                                    key_cmd.pos_b = tcode;
                                    n_pend_valid  = 1'b0;
                                    n_pend        = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FIN: begin
                key_cmd.place      = 1'b1;
                key_cmd.place_code = r_fin_k;
                if (r_fin_k == CODE_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_fin_k = r_fin_k + 5'd1;
                end
            end
            ST_POS: begin
                key_cmd.sq_rd = 1'b1;
                if (ar == br) begin
                    key_cmd.sq_a0 = cell_idx(ar, step5(ac, r_dir));
                    key_cmd.sq_a1 = cell_idx(ar, step5(bc, r_dir));
                end else if (ac == bc) begin
                    key_cmd.sq_a0 = cell_idx(step5(ar, r_dir), ac);
                    key_cmd.sq_a1 = cell_idx(step5(br, r_dir), ac);
                end else begin
                    key_cmd.sq_a0 = cell_idx(ar, bc);
                    key_cmd.sq_a1 = cell_idx(br, ac);
                end
                n_state = ST_EMA;
            end
            ST_EMA: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.out_char = CHAR_UA + {3'b000, key_rsp.q0};
                    n_out.last     = 1'b0;
                    n_state        = ST_EMB;
                end
            end
            ST_EMB: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.out_char = r_pass ? r_byte : (CHAR_UA + {3'b000, key_rsp.q1});
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_dir        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend       <= '0;
            r_fin_k      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_pend       <= n_pend;
            r_fin_k      <= n_fin_k;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass <= n_pass;
        r_byte <= n_byte;
        r_out  <= n_out;
    end

endmodule

### hw/rtl/pfc_checker.sv
// Port-level checker for the Playfair stream cipher, bound to the top level.
module pfc_checker
    import pfc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data,
    input logic i_cfg_we,
    input logic i_cfg_wdata
);

    logic in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_pair_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input taken while a pair is half delivered");

    a_key_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_data.op != OP_TEXT) |=> !o_out_valid || $past(o_out_valid))
        else $error("key operation produced a result");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !i_in_valid && !o_out_valid)
        else $error("configuration write while a transfer is in flight");

endmodule

bind playfair_stream_cipher_top pfc_checker u_pfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata)
);
